// ===== src/plvt_pkg.sv =====
`timescale 1ns / 1ps

package plvt_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 10;
  localparam int COORD_W   = INT_BITS + FRAC_BITS;
  localparam int GRID_W    = 11;
  localparam int CASE_W    = 4;

  // wrapped coordinates are signed and need room for the grid offset
  localparam int WRAP_W = ((COORD_W > GRID_W + FRAC_BITS) ? COORD_W : GRID_W + FRAC_BITS) + 2;
  localparam int DIFF_W = WRAP_W - 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINK_RADIUS     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_MARGIN = CFG_IDX_W'(2);

  localparam logic [GRID_W-1:0]  GRID_SIZE_RST       = GRID_W'(16);
  localparam logic [COORD_W-1:0] LINK_RADIUS_RST     = COORD_W'(65536);
  localparam logic [COORD_W-1:0] OBSTACLE_MARGIN_RST = COORD_W'(6554);

  // boundary cases
  localparam logic [CASE_W-1:0] EC_NONE       = CASE_W'(0);
  localparam logic [CASE_W-1:0] EC_WEST_SOUTH = CASE_W'(1);
  localparam logic [CASE_W-1:0] EC_SOUTH      = CASE_W'(2);
  localparam logic [CASE_W-1:0] EC_EAST_SOUTH = CASE_W'(3);
  localparam logic [CASE_W-1:0] EC_WEST       = CASE_W'(4);
  localparam logic [CASE_W-1:0] EC_EAST       = CASE_W'(5);
  localparam logic [CASE_W-1:0] EC_NORTH_WEST = CASE_W'(6);
  localparam logic [CASE_W-1:0] EC_NORTH      = CASE_W'(7);
  localparam logic [CASE_W-1:0] EC_NORTH_EAST = CASE_W'(8);

  // accept to result strobe, in cycles
  localparam int LATENCY = 6;

  typedef struct packed {
    logic [GRID_W-1:0]  grid_size;
    logic [COORD_W-1:0] link_radius;
    logic [COORD_W-1:0] obstacle_margin;
  } pt_cfg_t;

  typedef struct packed {
    logic [CASE_W-1:0]  edge_case;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
  } pt_item_t;

  typedef struct packed {
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
  } pt_diff_t;

endpackage

// ===== src/plvt_wrap.sv =====
`timescale 1ns / 1ps

module plvt_wrap (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  plvt_pkg::pt_item_t     item,
  input  logic [plvt_pkg::GRID_W-1:0] grid_size,
  output logic                   out_vld,
  output plvt_pkg::pt_diff_t     diff
);
  import plvt_pkg::*;

  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

  // move a coordinate across the grid when it sits on the wrapped side
  function automatic logic signed [WRAP_W-1:0] wrap_coord(
    input logic [COORD_W-1:0]       c,
    input logic                     low_side,
    input logic                     high_side,
    input logic signed [WRAP_W-1:0] g
  );
    logic signed [WRAP_W-1:0] v;
    v = $signed({{(WRAP_W-COORD_W){1'b0}}, c});
    if (low_side && (c > ONE)) begin
      v = v - g;
    end else if (high_side && (c <= ONE)) begin
      v = v + g;
    end
    return v;
  endfunction

  function automatic logic [DIFF_W-1:0] abs_diff(
    input logic signed [WRAP_W-1:0] a,
    input logic signed [WRAP_W-1:0] b
  );
    logic signed [WRAP_W:0] d;
    d = (WRAP_W+1)'(a) - (WRAP_W+1)'(b);
    if (d < 0) begin
      d = -d;
    end
    return d[DIFF_W-1:0];
  endfunction

  logic                     west, east, south, north;
  logic [GRID_W:0]          gm1;
  logic signed [WRAP_W-1:0] g;
  logic signed [WRAP_W-1:0] ax_next, ay_next, bx_next, by_next;
  logic signed [WRAP_W-1:0] ax, ay, bx, by;
  logic                     wrap_vld;

  // decode the boundary sides
  always_comb begin
    west  = (item.edge_case == EC_WEST_SOUTH) || (item.edge_case == EC_WEST) ||
            (item.edge_case == EC_NORTH_WEST);
    east  = (item.edge_case == EC_EAST_SOUTH) || (item.edge_case == EC_EAST) ||
            (item.edge_case == EC_NORTH_EAST);
    south = (item.edge_case == EC_WEST_SOUTH) || (item.edge_case == EC_SOUTH) ||
            (item.edge_case == EC_EAST_SOUTH);
    north = (item.edge_case == EC_NORTH_WEST) || (item.edge_case == EC_NORTH) ||
            (item.edge_case == EC_NORTH_EAST);
  end

  // grid offset (grid_size - 1) * one, negative for a zero grid
  assign gm1 = {1'b0, grid_size} - (GRID_W+1)'(1);
  assign g   = WRAP_W'($signed({gm1, {FRAC_BITS{1'b0}}}));

  assign ax_next = wrap_coord(item.first_x,  west,  east,  g);
  assign bx_next = wrap_coord(item.second_x, west,  east,  g);
  assign ay_next = wrap_coord(item.first_y,  south, north, g);
  assign by_next = wrap_coord(item.second_y, south, north, g);

  // wrapped coordinate stage
  always_ff @(posedge clk) begin
    ax <= ax_next;
    ay <= ay_next;
    bx <= bx_next;
    by <= by_next;
    if (rst) begin
      wrap_vld <= 1'b0;
    end else begin
      wrap_vld <= in_vld;
    end
  end

  // absolute difference stage
  always_ff @(posedge clk) begin
    diff.dx <= abs_diff(ax, bx);
    diff.dy <= abs_diff(ay, by);
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= wrap_vld;
    end
  end

endmodule

// ===== src/plvt_judge.sv =====
`timescale 1ns / 1ps

module plvt_judge (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  plvt_pkg::pt_diff_t diff,
  input  plvt_pkg::pt_cfg_t  cfg,
  output logic               done,
  output logic               linked
);
  import plvt_pkg::*;

  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_gt_r;
    logic dy_gt_r;
    logic dx_lt_eps;
    logic dy_lt_eps;
    logic dx_lt_w;
    logic dy_lt_w;
  } pt_flag_t;

  logic              c_vld;
  pt_flag_t          c_flag;
  logic [DIFF_W-1:0] c_dx, c_dy, c_adx, c_ady;

  logic              d_vld;
  pt_flag_t          d_flag;
  logic [PROD_W-1:0] d_sq_x, d_sq_y, d_rr;
  logic [PROD_W-1:0] d_cross_x, d_eps_x, d_cross_y, d_eps_y;

  logic [DIFF_W-1:0] eps_ext, r_ext;
  logic [DIFF_W:0]   w_ext;
  logic [SUM_W-1:0]  dist_sq;
  logic              too_far, clear_ok, linked_next;

  assign eps_ext = DIFF_W'(cfg.obstacle_margin);
  assign r_ext   = DIFF_W'(cfg.link_radius);
  assign w_ext   = (DIFF_W+1)'({cfg.obstacle_margin, 1'b0});

  // compare stage: flags and distances from eps
  always_ff @(posedge clk) begin
    c_dx             <= diff.dx;
    c_dy             <= diff.dy;
    c_adx            <= (diff.dx >= eps_ext) ? diff.dx - eps_ext : eps_ext - diff.dx;
    c_ady            <= (diff.dy >= eps_ext) ? diff.dy - eps_ext : eps_ext - diff.dy;
    c_flag.dx_zero   <= (diff.dx == '0);
    c_flag.dy_zero   <= (diff.dy == '0);
    c_flag.dx_gt_r   <= (diff.dx > r_ext);
    c_flag.dy_gt_r   <= (diff.dy > r_ext);
    c_flag.dx_lt_eps <= (diff.dx < eps_ext);
    c_flag.dy_lt_eps <= (diff.dy < eps_ext);
    c_flag.dx_lt_w   <= ({1'b0, diff.dx} < w_ext);
    c_flag.dy_lt_w   <= ({1'b0, diff.dy} < w_ext);
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= in_vld;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    d_sq_x    <= c_dx * c_dx;
    d_sq_y    <= c_dy * c_dy;
    d_rr      <= r_ext * r_ext;
    d_cross_x <= c_dy * c_adx;
    d_eps_x   <= eps_ext * c_dx;
    d_cross_y <= c_dx * c_ady;
    d_eps_y   <= eps_ext * c_dy;
    d_flag    <= c_flag;
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
  end

  // decision
  always_comb begin
    dist_sq  = SUM_W'(d_sq_x) + SUM_W'(d_sq_y);
    too_far  = dist_sq > SUM_W'(d_rr);
    clear_ok = d_flag.dx_lt_eps || d_flag.dy_lt_eps ||
               (d_flag.dx_lt_w && d_flag.dy_lt_w) ||
               (d_flag.dx_lt_w && (d_cross_x < d_eps_x)) ||
               (d_flag.dy_lt_w && (d_cross_y < d_eps_y));
    priority if (d_flag.dx_zero) begin
      linked_next = !d_flag.dy_gt_r;
    end else if (d_flag.dy_zero) begin
      linked_next = !d_flag.dx_gt_r;
    end else if (too_far) begin
      linked_next = 1'b0;
    end else begin
      linked_next = clear_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    linked <= linked_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld;
    end
  end

  // a pair with zero x distance is linked exactly when its y distance is within the radius
  a_axis_in_range : assert property (@(posedge clk) disable iff (rst)
    d_vld && d_flag.dx_zero && !d_flag.dy_gt_r |=> done && linked)
    else $error("aligned pair within radius not linked");

  a_axis_out_range : assert property (@(posedge clk) disable iff (rst)
    d_vld && d_flag.dx_zero && d_flag.dy_gt_r |=> done && !linked)
    else $error("aligned pair beyond radius linked");

  // the product stage and the result strobe stay in step
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !d_vld |=> !done)
    else $error("result strobe without a request in flight");

endmodule

// ===== src/periodic_link_visibility_test.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// request   in         start, busy               edge_case, first_x, first_y, second_x, second_y
// result    out        done (one-cycle strobe)   linked
// config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// one request per cycle; busy is never raised, so a request is taken at every start.
// each result strobes done for one cycle, after its request was taken.
// the latency is set by the six register stages: input, wrap, difference, compare,
// products and result.
// reset clears all stage valid bits and loads the register defaults; config is always ready.
// the receiver cannot stall, so nothing ever holds back the pipeline.

module periodic_link_visibility_test (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [plvt_pkg::CASE_W-1:0]   edge_case,
  input  logic [plvt_pkg::COORD_W-1:0]  first_x,
  input  logic [plvt_pkg::COORD_W-1:0]  first_y,
  input  logic [plvt_pkg::COORD_W-1:0]  second_x,
  input  logic [plvt_pkg::COORD_W-1:0]  second_y,
  output logic                          done,
  output logic                          linked,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plvt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import plvt_pkg::*;

  pt_cfg_t  cfg;
  pt_item_t item;
  logic     item_vld;
  logic     accept;
  logic     diff_vld;
  pt_diff_t diff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_size       <= GRID_SIZE_RST;
      cfg.link_radius     <= LINK_RADIUS_RST;
      cfg.obstacle_margin <= OBSTACLE_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_SIZE:       cfg.grid_size       <= cfg_data[GRID_W-1:0];
        REG_LINK_RADIUS:     cfg.link_radius     <= cfg_data[COORD_W-1:0];
        REG_OBSTACLE_MARGIN: cfg.obstacle_margin <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    item.edge_case <= edge_case;
    item.first_x   <= first_x;
    item.first_y   <= first_y;
    item.second_x  <= second_x;
    item.second_y  <= second_y;
    if (rst) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= accept;
    end
  end

  plvt_wrap u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (item_vld),
    .item      (item),
    .grid_size (cfg.grid_size),
    .out_vld   (diff_vld),
    .diff      (diff)
  );

  plvt_judge u_judge (
    .clk    (clk),
    .rst    (rst),
    .in_vld (diff_vld),
    .diff   (diff),
    .cfg    (cfg),
    .done   (done),
    .linked (linked)
  );

  // every result traces back to an earlier request that was taken
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching request");

endmodule
